### rtl/core/assert_macros.svh
// Assertion macros shared by the locator RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### rtl/core/ccbl_pkg.sv
// Types and constants of the color column ball locator.
// No dependencies; used by the channel interfaces and every RTL module.
package ccbl_pkg;

   localparam int COLOR_W     = 8;
   localparam int COUNT_W     = 7;
   localparam int COLUMN_W    = 6;
   localparam int PROX_W      = 12;
   localparam int STEER_W     = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int SQUARE_W    = 16;
   localparam int HUE_W       = 14;
   localparam int CHROMA_W    = 23;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // 1000*g > 1260*r reduces to 50*g > 63*r.
   localparam logic [HUE_W-1:0] HUE_G_MUL = 14'd50;
   localparam logic [HUE_W-1:0] HUE_R_MUL = 14'd63;
   // 100*(r2+g2) > 81*(r2+g2+b2) reduces to 19*(r2+g2) > 81*b2.
   localparam logic [CHROMA_W-1:0] CHROMA_RG_MUL = 23'd19;
   localparam logic [CHROMA_W-1:0] CHROMA_B_MUL  = 23'd81;

   localparam logic [COUNT_W-1:0]  MIN_COUNT_RESET  = 7'd5;
   localparam logic [COLUMN_W-1:0] LEFT_LIMIT_RESET = 6'd23;
   localparam logic [COLUMN_W-1:0] RIGHT_LIMIT_RESET = 6'd29;
   localparam logic [PROX_W-1:0]   NEAR_THRESH_RESET = 12'd105;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_COUNT   = 2'd0,
      CSR_LEFT_LIMIT  = 2'd1,
      CSR_RIGHT_LIMIT = 2'd2,
      CSR_NEAR_THRESH = 2'd3
   } csr_index_type;

   typedef enum logic [STEER_W-1:0] {
      STEER_CRUISE   = 3'd0,
      STEER_APPROACH = 3'd1,
      STEER_LEFT     = 3'd2,
      STEER_RIGHT    = 3'd3,
      STEER_REACHED  = 3'd4
   } steer_type;

   typedef struct packed {
      logic              column_end;
      logic              frame_end;
      logic [PROX_W-1:0] proximity;
   } pixel_tag_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      pixel_tag_type      tag;
   } pixel_type;

   typedef struct packed {
      logic          match;
      pixel_tag_type tag;
   } pix_class_type;

   typedef struct packed {
      logic              present;
      logic [PROX_W-1:0] proximity;
   } frame_sum_type;

endpackage

### rtl/core/ccbl_if.sv
// Valid/ready channel interfaces of the locator: pixels, results, register writes.
// Depends on ccbl_pkg for field widths.
interface ccbl_req_if;
   logic                             valid;
   logic                             ready;
   logic [ccbl_pkg::COLOR_W-1:0]     red;
   logic [ccbl_pkg::COLOR_W-1:0]     green;
   logic [ccbl_pkg::COLOR_W-1:0]     blue;
   logic                             column_end;
   logic                             frame_end;
   logic [ccbl_pkg::PROX_W-1:0]      front_proximity;

   modport source (output valid, red, green, blue, column_end, frame_end, front_proximity,
                   input ready);
   modport sink (input valid, red, green, blue, column_end, frame_end, front_proximity,
                 output ready);
endinterface

interface ccbl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             ball_present;
   logic [ccbl_pkg::COLUMN_W-1:0]    ball_column;
   logic [ccbl_pkg::STEER_W-1:0]     steer;

   modport source (output valid, ball_present, ball_column, steer, input ready);
   modport sink (input valid, ball_present, ball_column, steer, output ready);
endinterface

interface ccbl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ccbl_pkg::CSR_INDEX_W-1:0] index;
   logic [ccbl_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/color_column_ball_locator.sv
// Top level of the color column ball locator: register file, pipeline stall, checks.
// Depends on ccbl_pkg, ccbl_if.sv, ccbl_classifier, ccbl_accumulator, ccbl_steer.
//
//  Channel  Direction  Carries                                      Transfer when
//  req_if   in         one pixel: r, g, b, column/frame end, prox   valid && ready
//  rsp_if   out        ball_present, ball_column, steer per frame   valid && ready
//  csr_if   in         register index and write data                valid && ready
//
// One pixel is taken every clock cycle unless the pipeline is stalled. A frame result is offered
// once the pixel that ends the frame has passed five registers: the input register, loaded
// at that transfer, the squares stage, the match stage, the column accumulator with its summary
// register, and the result register.
// Reset is synchronous and active high; it empties the pipeline, clears the frame
// state and loads the register defaults (5, 23, 29, 105).
// The pixel side stalls only when a finished frame summary waits behind a result that
// the sink has not yet taken; the result register and the summary stage hold two
// frame results between them. Register writes are always taken at once.
`include "assert_macros.svh"

module color_column_ball_locator #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic       clock,
   input  logic       reset,
   ccbl_req_if.sink   req_if,
   ccbl_rsp_if.source rsp_if,
   ccbl_csr_if.sink   csr_if
);

   localparam int IdxW = $clog2(MAX_COLUMNS);

   // Configuration registers.
   logic [ccbl_pkg::COUNT_W-1:0]  min_count_ff;
   logic [ccbl_pkg::COLUMN_W-1:0] left_limit_ff;
   logic [ccbl_pkg::COLUMN_W-1:0] right_limit_ff;
   logic [ccbl_pkg::PROX_W-1:0]   near_thresh_ff;
   ccbl_pkg::csr_index_type       csr_index;

   ccbl_pkg::pixel_type           in_pix;
   logic                          en;
   logic                          cls_valid;
   ccbl_pkg::pix_class_type       cls;
   logic                          sum_valid;
   ccbl_pkg::frame_sum_type       sum;
   logic [IdxW-1:0]               sum_pos;

   // The register port never pushes back; fields wider than a register are cut
   // to its width.
   assign csr_if.ready = 1'b1;
   assign csr_index    = ccbl_pkg::csr_index_type'(csr_if.index);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_count_ff   <= ccbl_pkg::MIN_COUNT_RESET;
         left_limit_ff  <= ccbl_pkg::LEFT_LIMIT_RESET;
         right_limit_ff <= ccbl_pkg::RIGHT_LIMIT_RESET;
         near_thresh_ff <= ccbl_pkg::NEAR_THRESH_RESET;
      end else if (csr_if.valid) begin
         case (csr_index)
            ccbl_pkg::CSR_MIN_COUNT: begin
               min_count_ff <= csr_if.data[ccbl_pkg::COUNT_W-1:0];
            end
            ccbl_pkg::CSR_LEFT_LIMIT: begin
               left_limit_ff <= csr_if.data[ccbl_pkg::COLUMN_W-1:0];
            end
            ccbl_pkg::CSR_RIGHT_LIMIT: begin
               right_limit_ff <= csr_if.data[ccbl_pkg::COLUMN_W-1:0];
            end
            ccbl_pkg::CSR_NEAR_THRESH: begin
               near_thresh_ff <= csr_if.data[ccbl_pkg::PROX_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline moves together. It holds only while a frame summary is
   // parked in front of an occupied result register that is not being drained.
   assign en           = !(sum_valid && rsp_if.valid && !rsp_if.ready);
   assign req_if.ready = en;

   always_comb begin
      in_pix.red           = req_if.red;
      in_pix.green         = req_if.green;
      in_pix.blue          = req_if.blue;
      in_pix.tag.column_end = req_if.column_end;
      in_pix.tag.frame_end  = req_if.frame_end;
      in_pix.tag.proximity  = req_if.front_proximity;
   end

   ccbl_classifier u_classifier (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .in_pix    (in_pix),
      .cls_valid (cls_valid),
      .cls       (cls)
   );

   ccbl_accumulator #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_accumulator (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cls_valid (cls_valid),
      .cls       (cls),
      .min_count (min_count_ff),
      .sum_valid (sum_valid),
      .sum       (sum),
      .sum_pos   (sum_pos)
   );

   ccbl_steer #(
      .POS_W (IdxW)
   ) u_steer (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .sum_valid      (sum_valid),
      .sum            (sum),
      .sum_pos        (sum_pos),
      .left_limit     (left_limit_ff),
      .right_limit    (right_limit_ff),
      .near_threshold (near_thresh_ff),
      .rsp_if         (rsp_if)
   );

   // The pixel side may only be held off by an untaken result.
   `ASSERT_CLK(a_stall_cause, clock, reset, !req_if.ready |-> (rsp_if.valid && !rsp_if.ready), "pixel input stalled without result backpressure")
   // Nothing is offered right after reset.
   `ASSERT_CLK(a_reset_empty, clock, reset, $past(reset) |-> !rsp_if.valid, "result offered right after reset")
   // Without a ball the column reads zero and the robot cruises.
   `ASSERT_CLK(a_no_ball_fields, clock, reset, (rsp_if.valid && !rsp_if.ball_present) |-> (rsp_if.ball_column == '0 && rsp_if.steer == ccbl_pkg::STEER_CRUISE), "no-ball result with column or steer set")
   // With a ball the robot never cruises.
   `ASSERT_CLK(a_ball_steer, clock, reset, (rsp_if.valid && rsp_if.ball_present) |-> (rsp_if.steer != ccbl_pkg::STEER_CRUISE), "ball result with cruise steering")
   `ASSERT_NEVER(a_steer_range, clock, reset, rsp_if.valid && (rsp_if.steer > ccbl_pkg::STEER_REACHED), "steering code out of range")

endmodule

### rtl/core/ccbl_classifier.sv
// Pixel color classifier: input register, squares stage, and match decision stage.
// Depends on ccbl_pkg.
module ccbl_classifier (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  ccbl_pkg::pixel_type     in_pix,
   output logic                    cls_valid,
   output ccbl_pkg::pix_class_type cls
);

   logic                              pix_valid_ff;
   ccbl_pkg::pixel_type               pix_ff;

   logic                              sq_valid_ff;
   logic [ccbl_pkg::SQUARE_W-1:0]     sq_r_ff, sq_g_ff, sq_b_ff;
   logic [ccbl_pkg::SQUARE_W-1:0]     sq_r_in, sq_g_in, sq_b_in;
   logic                              hue_ok_ff, hue_ok_in;
   ccbl_pkg::pixel_tag_type           sq_tag_ff;

   logic                              cls_valid_ff;
   ccbl_pkg::pix_class_type           cls_ff, cls_in;

   logic [ccbl_pkg::HUE_W-1:0]        hue_lhs, hue_rhs;
   logic [ccbl_pkg::SQUARE_W:0]       rg_sum;
   logic [ccbl_pkg::CHROMA_W-1:0]     chroma_lhs, chroma_rhs;

   // Squares and the hue test.
   always_comb begin
      sq_r_in   = {8'd0, pix_ff.red}   * {8'd0, pix_ff.red};
      sq_g_in   = {8'd0, pix_ff.green} * {8'd0, pix_ff.green};
      sq_b_in   = {8'd0, pix_ff.blue}  * {8'd0, pix_ff.blue};
      hue_lhs   = ccbl_pkg::HUE_W'(pix_ff.green) * ccbl_pkg::HUE_G_MUL;
      hue_rhs   = ccbl_pkg::HUE_W'(pix_ff.red)   * ccbl_pkg::HUE_R_MUL;
      hue_ok_in = hue_lhs > hue_rhs;
   end

   // Chroma test; a black pixel fails the strict hue compare.
   always_comb begin
      rg_sum       = {1'b0, sq_r_ff} + {1'b0, sq_g_ff};
      chroma_lhs   = ccbl_pkg::CHROMA_W'(rg_sum)  * ccbl_pkg::CHROMA_RG_MUL;
      chroma_rhs   = ccbl_pkg::CHROMA_W'(sq_b_ff) * ccbl_pkg::CHROMA_B_MUL;
      cls_in.match = hue_ok_ff && (chroma_lhs > chroma_rhs);
      cls_in.tag   = sq_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         cls_valid_ff <= 1'b0;
      end else if (en) begin
         pix_valid_ff <= in_valid;
         sq_valid_ff  <= pix_valid_ff;
         cls_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff    <= in_pix;
         sq_r_ff   <= sq_r_in;
         sq_g_ff   <= sq_g_in;
         sq_b_ff   <= sq_b_in;
         hue_ok_ff <= hue_ok_in;
         sq_tag_ff <= pix_ff.tag;
         cls_ff    <= cls_in;
      end
   end

   assign cls_valid = cls_valid_ff;
   assign cls       = cls_ff;

endmodule

### rtl/core/ccbl_accumulator.sv
// Per-column match counter, best-column tracker and frame summary register.
// Depends on ccbl_pkg.
module ccbl_accumulator #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            cls_valid,
   input  ccbl_pkg::pix_class_type         cls,
   input  logic [ccbl_pkg::COUNT_W-1:0]    min_count,
   output logic                            sum_valid,
   output ccbl_pkg::frame_sum_type         sum,
   output logic [$clog2(MAX_COLUMNS)-1:0]  sum_pos
);

   localparam int IdxW = $clog2(MAX_COLUMNS);
   localparam int PosW = IdxW + 1;

   logic [ccbl_pkg::COUNT_W-1:0] col_cnt_ff, col_cnt_in;
   logic [PosW-1:0]              col_pos_ff, col_pos_in;
   logic [ccbl_pkg::COUNT_W-1:0] best_cnt_ff, best_cnt_in;
   logic [IdxW-1:0]              best_pos_ff, best_pos_in;
   logic                         flag_ff, flag_in;

   logic                         sum_valid_ff, sum_valid_in;
   ccbl_pkg::frame_sum_type      sum_ff, sum_in;
   logic [IdxW-1:0]              sum_pos_ff, sum_pos_in;

   logic                         in_range, step, close_col;
   logic [ccbl_pkg::COUNT_W-1:0] cnt_now;

   always_comb begin
      in_range  = col_pos_ff < PosW'(MAX_COLUMNS);
      step      = en && cls_valid;
      close_col = cls.tag.column_end || cls.tag.frame_end;

      cnt_now = col_cnt_ff;
      if (in_range && cls.match && (col_cnt_ff != ccbl_pkg::COUNT_MAX)) begin
         cnt_now = col_cnt_ff + 1'b1;
      end

      col_cnt_in  = cnt_now;
      col_pos_in  = col_pos_ff;
      best_cnt_in = best_cnt_ff;
      best_pos_in = best_pos_ff;
      flag_in     = flag_ff;

      if (close_col) begin
         col_cnt_in = '0;
         if (in_range) begin
            // Strictly greater keeps the earliest column on a tie.
            if (cnt_now > best_cnt_ff) begin
               best_cnt_in = cnt_now;
               best_pos_in = col_pos_ff[IdxW-1:0];
            end
            if (cnt_now > min_count) begin
               flag_in = 1'b1;
            end
            col_pos_in = col_pos_ff + 1'b1;
         end
      end

      sum_valid_in      = cls_valid && cls.tag.frame_end;
      sum_in.present    = flag_in;
      sum_in.proximity  = cls.tag.proximity;
      sum_pos_in        = flag_in ? best_pos_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         col_pos_ff  <= '0;
         best_cnt_ff <= '0;
         best_pos_ff <= '0;
         flag_ff     <= 1'b0;
      end else if (step) begin
         if (cls.tag.frame_end) begin
            col_cnt_ff  <= '0;
            col_pos_ff  <= '0;
            best_cnt_ff <= '0;
            best_pos_ff <= '0;
            flag_ff     <= 1'b0;
         end else begin
            col_cnt_ff  <= col_cnt_in;
            col_pos_ff  <= col_pos_in;
            best_cnt_ff <= best_cnt_in;
            best_pos_ff <= best_pos_in;
            flag_ff     <= flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (en) begin
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff     <= sum_in;
         sum_pos_ff <= sum_pos_in;
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum       = sum_ff;
   assign sum_pos   = sum_pos_ff;

endmodule

### rtl/core/ccbl_steer.sv
// Steering decision and result register driving the result channel.
// Depends on ccbl_pkg and the ccbl_rsp_if interface.
module ccbl_steer #(
   parameter int POS_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          sum_valid,
   input  ccbl_pkg::frame_sum_type       sum,
   input  logic [POS_W-1:0]              sum_pos,
   input  logic [ccbl_pkg::COLUMN_W-1:0] left_limit,
   input  logic [ccbl_pkg::COLUMN_W-1:0] right_limit,
   input  logic [ccbl_pkg::PROX_W-1:0]   near_threshold,
   ccbl_rsp_if.source                    rsp_if
);

   localparam int ExtW = (POS_W > ccbl_pkg::COLUMN_W) ? POS_W : ccbl_pkg::COLUMN_W;

   logic                          rsp_valid_ff;
   logic                          present_ff;
   logic [ccbl_pkg::COLUMN_W-1:0] column_ff, column_in;
   ccbl_pkg::steer_type           steer_ff, steer_in;

   logic [ExtW-1:0]               pos_ext, left_ext, right_ext;
   logic                          load;

   always_comb begin
      pos_ext   = ExtW'(sum_pos);
      left_ext  = ExtW'(left_limit);
      right_ext = ExtW'(right_limit);
      column_in = pos_ext[ccbl_pkg::COLUMN_W-1:0];
      if (!sum.present) begin
         steer_in = ccbl_pkg::STEER_CRUISE;
      end else if (sum.proximity > near_threshold) begin
         steer_in = ccbl_pkg::STEER_REACHED;
      end else if (pos_ext > right_ext) begin
         steer_in = ccbl_pkg::STEER_RIGHT;
      end else if (pos_ext < left_ext) begin
         steer_in = ccbl_pkg::STEER_LEFT;
      end else begin
         steer_in = ccbl_pkg::STEER_APPROACH;
      end
   end

   assign load = en && sum_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         present_ff <= sum.present;
         column_ff  <= column_in;
         steer_ff   <= steer_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.ball_present = present_ff;
   assign rsp_if.ball_column  = column_ff;
   assign rsp_if.steer        = steer_ff;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for color_column_ball_locator: drives pixel frames and register writes,
// checks each frame report against an in-bench predictor. Depends on ccbl_pkg and ccbl_if.sv.
module tb;

   // The block is built with its default column limit, and the predictor mirrors it.
   localparam int MAX_COLS      = 64;
   localparam int CYCLE_LIMIT   = 400000;
   // Cycles allowed after the last report for the five-stage pipeline to empty.
   localparam int SETTLE_CYCLES = 16;
   localparam int DIRECTED_ROWS = 22;
   localparam int SEGMENTS      = 9;
   localparam int SEGMENT_ITEMS = 189;

   // One pixel as it crosses the request channel.
   typedef struct packed {
      logic [ccbl_pkg::COLOR_W-1:0] red;
      logic [ccbl_pkg::COLOR_W-1:0] green;
      logic [ccbl_pkg::COLOR_W-1:0] blue;
      logic                         column_end;
      logic                         frame_end;
      logic [ccbl_pkg::PROX_W-1:0]  proximity;
   } pixel_item_type;

   // One frame report as it crosses the response channel.
   typedef struct packed {
      logic                          present;
      logic [ccbl_pkg::COLUMN_W-1:0] column;
      ccbl_pkg::steer_type           steer;
   } frame_report_type;

   // A row of the directed script. When hand_checked is set, the report typed into the row
   // is what the frame must produce; otherwise the predictor supplies it.
   typedef struct packed {
      pixel_item_type   px;
      logic             hand_checked;
      frame_report_type report;
   } script_row_type;

   // The report of a frame without a ball; also the filler of rows the predictor checks.
   localparam frame_report_type NO_REPORT = '{1'b0, '0, ccbl_pkg::STEER_CRUISE};

   logic clock;
   logic reset;

   ccbl_req_if req_ch ();
   ccbl_rsp_if rsp_ch ();
   ccbl_csr_if csr_ch ();

   color_column_ball_locator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Register copies held by the predictor. They change only when a register transfer
   // is seen, so they always match what the block holds.
   logic [ccbl_pkg::COUNT_W-1:0]  cfg_min_count;
   logic [ccbl_pkg::COLUMN_W-1:0] cfg_left_limit;
   logic [ccbl_pkg::COLUMN_W-1:0] cfg_right_limit;
   logic [ccbl_pkg::PROX_W-1:0]   cfg_near_thresh;

   // Frame state of the predictor. The column index is two bits wider than a column
   // number so that it can sit at MAX_COLS once the frame runs past the last column.
   logic [ccbl_pkg::COUNT_W-1:0]  col_hits;
   logic [ccbl_pkg::COUNT_W:0]    col_index;
   logic [ccbl_pkg::COUNT_W-1:0]  best_hits;
   logic [ccbl_pkg::COLUMN_W-1:0] best_column;
   logic                          ball_seen;

   frame_report_type reports_due [$];
   script_row_type   script [DIRECTED_ROWS];

   int cycle_count;
   int mismatch_count;
   int pixels_sent;
   int send_idle_pct;
   int recv_idle_pct;

   initial begin
      clock = 1'b0;
   end

   always #6 clock = ~clock;

   // Watchdog. A hung handshake or a report that never arrives ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // The result sink stalls at random. The stall rate is changed by the main sequence
   // between phases; the draw happens on the falling edge so the block sees a stable
   // ready at the next rising edge.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Integer form of the two color tests: green over red above tan(0.9), and the
   // red-green share of the color energy above 0.81. Black fails the second test.
   function automatic bit is_target_color(logic [ccbl_pkg::COLOR_W-1:0] r,
                                          logic [ccbl_pkg::COLOR_W-1:0] g,
                                          logic [ccbl_pkg::COLOR_W-1:0] b);
      int ri;
      int gi;
      int bi;
      int rg_sq;
      int all_sq;
      ri = r;
      gi = g;
      bi = b;
      rg_sq = ri * ri + gi * gi;
      all_sq = rg_sq + bi * bi;
      return (1000 * gi > 1260 * ri) && (100 * rg_sq > 81 * all_sq);
   endfunction

   // Advances the predictor by one accepted pixel. When the pixel ends a frame, the
   // report is returned and the frame state is cleared.
   function automatic void track_pixel(input pixel_item_type px, output bit frame_done,
                                       output frame_report_type report);
      frame_done = 1'b0;
      report = NO_REPORT;
      // Columns past the last one are ignored entirely: no count, no best column.
      if (col_index < MAX_COLS && is_target_color(px.red, px.green, px.blue) &&
          col_hits != ccbl_pkg::COUNT_MAX) begin
         col_hits = col_hits + 1'b1;
      end
      // A frame end closes the open column even without its column end flag.
      if (px.column_end || px.frame_end) begin
         if (col_index < MAX_COLS) begin
            // Strictly greater, so the earliest column keeps a tied count.
            if (col_hits > best_hits) begin
               best_hits = col_hits;
               best_column = col_index[ccbl_pkg::COLUMN_W-1:0];
            end
            if (col_hits > cfg_min_count) begin
               ball_seen = 1'b1;
            end
            col_index = col_index + 1'b1;
         end
         col_hits = '0;
      end
      if (px.frame_end) begin
         frame_done = 1'b1;
         report.present = ball_seen;
         report.column = ball_seen ? best_column : '0;
         // Reached wins over the turns; a turn right wins over a turn left, so a column
         // sitting exactly on a limit means approach.
         if (!ball_seen) begin
            report.steer = ccbl_pkg::STEER_CRUISE;
         end else if (px.proximity > cfg_near_thresh) begin
            report.steer = ccbl_pkg::STEER_REACHED;
         end else if (best_column > cfg_right_limit) begin
            report.steer = ccbl_pkg::STEER_RIGHT;
         end else if (best_column < cfg_left_limit) begin
            report.steer = ccbl_pkg::STEER_LEFT;
         end else begin
            report.steer = ccbl_pkg::STEER_APPROACH;
         end
         col_hits = '0;
         col_index = '0;
         best_hits = '0;
         best_column = '0;
         ball_seen = 1'b0;
      end
   endfunction

   // Every report that leaves the block is matched against the oldest one due.
   always @(posedge clock) begin
      frame_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reports_due.size() == 0) begin
            $error("unexpected report: present %0d column %0d steer %0d",
                   rsp_ch.ball_present, rsp_ch.ball_column, rsp_ch.steer);
            mismatch_count++;
         end else begin
            want = reports_due.pop_front();
            if (rsp_ch.ball_present !== want.present) begin
               $error("ball_present: expected %0d, actual %0d",
                      want.present, rsp_ch.ball_present);
               mismatch_count++;
            end
            if (rsp_ch.ball_column !== want.column) begin
               $error("ball_column: expected %0d, actual %0d", want.column, rsp_ch.ball_column);
               mismatch_count++;
            end
            if (rsp_ch.steer !== want.steer) begin
               $error("steer: expected %0d, actual %0d", want.steer, rsp_ch.steer);
               mismatch_count++;
            end
         end
      end
   end

   // Presents one pixel, holding it until the transfer. The task is entered and left on
   // a falling edge. Valid is lowered only for idle cycles and raised again at a later falling
   // edge, so it never gets two assignments in one time step.
   task automatic send_pixel(input pixel_item_type px, input bit hand_checked,
                             input frame_report_type hand_report);
      bit frame_done;
      frame_report_type report;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.red = px.red;
      req_ch.green = px.green;
      req_ch.blue = px.blue;
      req_ch.column_end = px.column_end;
      req_ch.frame_end = px.frame_end;
      req_ch.front_proximity = px.proximity;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      // The transfer has happened at this edge; the report lands in the queue before the
      // block can offer it.
      track_pixel(px, frame_done, report);
      if (frame_done) begin
         reports_due.push_back(hand_checked ? hand_report : report);
      end
      pixels_sent++;
      @(negedge clock);
   endtask

   // One register transfer. Valid stays high for a following write; the caller lowers it.
   task automatic write_csr(input ccbl_pkg::csr_index_type index,
                            input logic [ccbl_pkg::CSR_DATA_W-1:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data = value;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
      case (index)
         ccbl_pkg::CSR_MIN_COUNT:   cfg_min_count = value[ccbl_pkg::COUNT_W-1:0];
         ccbl_pkg::CSR_LEFT_LIMIT:  cfg_left_limit = value[ccbl_pkg::COLUMN_W-1:0];
         ccbl_pkg::CSR_RIGHT_LIMIT: cfg_right_limit = value[ccbl_pkg::COLUMN_W-1:0];
         ccbl_pkg::CSR_NEAR_THRESH: cfg_near_thresh = value[ccbl_pkg::PROX_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_regs(input int min_count, input int left_limit,
                               input int right_limit, input int near_thresh);
      write_csr(ccbl_pkg::CSR_MIN_COUNT, ccbl_pkg::CSR_DATA_W'(min_count));
      write_csr(ccbl_pkg::CSR_LEFT_LIMIT, ccbl_pkg::CSR_DATA_W'(left_limit));
      write_csr(ccbl_pkg::CSR_RIGHT_LIMIT, ccbl_pkg::CSR_DATA_W'(right_limit));
      write_csr(ccbl_pkg::CSR_NEAR_THRESH, ccbl_pkg::CSR_DATA_W'(near_thresh));
      csr_ch.valid = 1'b0;
   endtask

   // Holds the pixel side back until every report due has arrived, then lets the
   // pipeline run empty. Registers are only written after this.
   task automatic wait_for_reports();
      req_ch.valid = 1'b0;
      while (reports_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Draws one pixel. A target pixel is built to pass both color tests; the others mix
   // fully random colors with colors sitting right at the hue or chroma boundary.
   function automatic pixel_item_type make_pixel(input bit target);
      pixel_item_type px;
      int r;
      int g;
      int b;
      int flavor;
      flavor = $urandom_range(9);
      if (target) begin
         g = $urandom_range(255, 1);
         r = $urandom_range((50 * g - 1) / 63, 0);
         b = $urandom_range((48 * g) / 100, 0);
      end else if (flavor <= 4) begin
         r = $urandom_range(255);
         g = $urandom_range(255);
         b = $urandom_range(255);
      end else if (flavor <= 6) begin
         // Red at or just past the hue limit for this green.
         g = $urandom_range(255);
         r = (50 * g) / 63 + $urandom_range(1);
         b = $urandom_range((48 * g) / 100, 0);
      end else if (flavor <= 8) begin
         // Blue on either side of the chroma limit.
         g = $urandom_range(255, 1);
         r = 0;
         b = (484 * g) / 1000 + $urandom_range(1);
      end else begin
         r = $urandom_range(1) * 255;
         g = $urandom_range(1) * 255;
         b = $urandom_range(1) * 255;
      end
      px.red = ccbl_pkg::COLOR_W'(r);
      px.green = ccbl_pkg::COLOR_W'(g);
      px.blue = ccbl_pkg::COLOR_W'(b);
      px.column_end = 1'b0;
      px.frame_end = 1'b0;
      px.proximity = ccbl_pkg::PROX_W'($urandom_range(4095));
      return px;
   endfunction

   // Sends one well-formed frame with random content. Most frames are narrow; a few run
   // past the last column, and a few carry a column tall enough to saturate its count.
   // One or two hot columns of pure target pixels decide the best column, and two hot
   // columns of the same height produce a tie.
   task automatic run_frame();
      int shape;
      int ncols;
      int hot_rows;
      int hot_a;
      int hot_b;
      int rows;
      bit hot;
      bit last_row;
      bit last_col;
      pixel_item_type px;
      shape = $urandom_range(39);
      if (shape == 0) begin
         ncols = $urandom_range(2, 1);
         hot_rows = $urandom_range(140, 128);
      end else if (shape <= 2) begin
         ncols = $urandom_range(68, 60);
         hot_rows = $urandom_range(10, 4);
      end else begin
         ncols = $urandom_range(6, 1);
         hot_rows = $urandom_range(12, 4);
      end
      hot_a = $urandom_range(ncols - 1);
      hot_b = $urandom_range(1) ? int'($urandom_range(ncols - 1)) : hot_a;
      for (int c = 0; c < ncols; c++) begin
         hot = (c == hot_a) || (c == hot_b);
         if (hot) begin
            rows = hot_rows;
         end else if (shape <= 2) begin
            rows = $urandom_range(2, 1);
         end else begin
            rows = $urandom_range(10, 1);
         end
         last_col = (c == ncols - 1);
         for (int r = 0; r < rows; r++) begin
            last_row = (r == rows - 1);
            px = make_pixel(hot || ($urandom_range(9) < 3));
            if (last_row && last_col) begin
               // The last pixel may or may not carry its own column end.
               px.frame_end = 1'b1;
               px.column_end = 1'($urandom_range(1));
               case ($urandom_range(4))
                  0: px.proximity = cfg_near_thresh;
                  1: px.proximity = cfg_near_thresh + 1'b1;
                  2: px.proximity = '0;
                  3: px.proximity = '1;
                  default: ;
               endcase
            end else if (last_row) begin
               px.column_end = 1'b1;
            end else begin
               // Now and then a stray column end splits a column.
               px.column_end = ($urandom_range(39) == 0);
            end
            send_pixel(px, 1'b0, NO_REPORT);
         end
      end
   endtask

   initial begin
      int goal;
      int min_count;
      int left_limit;
      int right_limit;
      int near_thresh;

      // Every input is known from time zero, and reset is held high at the start.
      reset = 1'b1;
      cycle_count = 0;
      mismatch_count = 0;
      pixels_sent = 0;
      send_idle_pct = 27;
      recv_idle_pct = 59;
      req_ch.valid = 1'b0;
      req_ch.red = '0;
      req_ch.green = '0;
      req_ch.blue = '0;
      req_ch.column_end = 1'b0;
      req_ch.frame_end = 1'b0;
      req_ch.front_proximity = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = ccbl_pkg::CSR_MIN_COUNT;
      csr_ch.data = '0;

      // The predictor starts from the register defaults and an empty frame.
      cfg_min_count = ccbl_pkg::MIN_COUNT_RESET;
      cfg_left_limit = ccbl_pkg::LEFT_LIMIT_RESET;
      cfg_right_limit = ccbl_pkg::RIGHT_LIMIT_RESET;
      cfg_near_thresh = ccbl_pkg::NEAR_THRESH_RESET;
      col_hits = '0;
      col_index = '0;
      best_hits = '0;
      best_column = '0;
      ball_seen = 1'b0;

      // Directed frames, run on the reset defaults (minimum 5, limits 23 and 29,
      // threshold 105).
      script = '{
         // A lone black pixel that ends the frame without a column end.
         '{'{8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 12'd4095}, 1'b1, NO_REPORT},
         // Six pure green pixels in column 0, one over the minimum; proximity one over
         // the threshold means the ball is reached.
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd4095}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd2730}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd1365}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 12'd106}, 1'b1,
           '{1'b1, 6'd0, ccbl_pkg::STEER_REACHED}},
         // Color extremes and pixels on both sides of the hue and chroma limits, over
         // three columns, the last one closed by the frame end alone.
         '{'{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 12'd4095}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd1, 8'd0, 1'b1, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd50, 8'd63, 8'd0, 1'b0, 1'b0, 12'd2730}, 1'b0, NO_REPORT},
         '{'{8'd49, 8'd63, 8'd0, 1'b0, 1'b0, 12'd1365}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd200, 8'd96, 1'b1, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd200, 8'd97, 1'b0, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd255, 8'd0, 8'd255, 1'b0, 1'b0, 12'd4095}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b1, 12'd105}, 1'b0, NO_REPORT},
         // An empty column 0, then six matches in column 1, left of the left limit.
         '{'{8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 12'd0}, 1'b0, NO_REPORT},
         '{'{8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 12'd0}, 1'b1,
           '{1'b1, 6'd1, ccbl_pkg::STEER_LEFT}}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_pixel(script[i].px, script[i].hand_checked, script[i].report);
      end

      // Random frames in nine phases. Each phase starts with the pixel side paused until
      // all reports are in, then a fresh register setting. The first three phases have
      // the sender idling lightly and the sink stalling heavily, the next three the
      // reverse, and the last three run with no idling at all.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 3) begin
            send_idle_pct = 27;
            recv_idle_pct = 59;
         end else if (seg < 6) begin
            send_idle_pct = 59;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_for_reports();
         case (seg)
            0: begin
               // Low extremes of the count and limits; the threshold at its top, so
               // every present ball means approach.
               min_count = 0;
               left_limit = 0;
               right_limit = 63;
               near_thresh = 4095;
            end
            1: begin
               // High extremes; only a column with more than 64 matches can make a ball.
               min_count = 64;
               left_limit = 63;
               right_limit = 0;
               near_thresh = 0;
            end
            2: begin
               // A minimum no 7-bit count can exceed.
               min_count = 127;
               left_limit = 3;
               right_limit = 3;
               near_thresh = 2048;
            end
            3: begin
               min_count = ccbl_pkg::MIN_COUNT_RESET;
               left_limit = ccbl_pkg::LEFT_LIMIT_RESET;
               right_limit = ccbl_pkg::RIGHT_LIMIT_RESET;
               near_thresh = ccbl_pkg::NEAR_THRESH_RESET;
            end
            default: begin
               // Limits near the narrow frames' columns so that all steering codes occur.
               min_count = $urandom_range(4);
               left_limit = $urandom_range(8);
               right_limit = $urandom_range(8);
               near_thresh = $urandom_range(4095);
            end
         endcase
         program_regs(min_count, left_limit, right_limit, near_thresh);
         goal = DIRECTED_ROWS + (seg + 1) * SEGMENT_ITEMS;
         while (pixels_sent < goal) begin
            run_frame();
         end
      end

      // Every frame ends in a report, so an empty queue plus a settle period means the
      // block is done; a report that never comes trips the watchdog instead.
      wait_for_reports();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
